>>> rtl/core/sbc_pkg.sv
// Shared types and constants for the sphere versus box classifier.
`timescale 1ns / 1ps

package sbc_pkg;

  localparam int COORD_WIDTH    = 16;
  localparam int RADIUS_WIDTH   = COORD_WIDTH - 1;
  localparam int DIST_WIDTH     = COORD_WIDTH;
  localparam int SQ_WIDTH       = 2 * DIST_WIDTH;
  localparam int SUM_WIDTH      = SQ_WIDTH + 2;
  localparam int RSQ_WIDTH      = 2 * RADIUS_WIDTH;
  localparam int NUM_REGS       = 6;
  localparam int ADDR_WIDTH     = 5;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int IN_BITS        = 3 * COORD_WIDTH + RADIUS_WIDTH;
  localparam int IN_TDATA_WIDTH = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = 8;

  typedef enum logic [1:0] {
    REL_DISJOINT   = 2'd0,
    REL_INTERSECTS = 2'd1,
    REL_CONTAINS   = 2'd2
  } relation_t;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  // Load enables of the first two pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
  } sbc_adv_t;

endpackage

>>> rtl/core/sphere_box_classify.sv
// Top level of the sphere versus axis-aligned box classifier.
`timescale 1ns / 1ps
// Classifies each sphere request (center x/y/z, signed Q12.4, and radius,
// unsigned Q11.4) against the box held in six APB registers at byte addresses
// 0x00..0x14 (min x, y, z, then max x, y, z; signed, reset 0). The result is
// 0 disjoint, 1 intersects (touching included), 2 sphere contained in the box
// with inclusive bounds. The test is exact: squared distances to the nearer
// faces are summed at full width and compared with the squared radius.
// Throughput is one request per clock while m_tready allows. Each request
// passes four pipeline stages (face distance, square, sum, classify) and then
// a two-entry output buffer. The pipeline stalls stage by stage, so bubbles
// collapse and back-pressure on the master side never drops a result.
// Write the box registers only while no request is in flight.

module sphere_box_classify
  import sbc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ADDR_WIDTH-1:0]      paddr,
  input  logic [CFG_DATA_WIDTH-1:0]  pwdata,
  output logic [CFG_DATA_WIDTH-1:0]  prdata,
  output logic                       pready,
  // Sphere requests
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // center_x [15:0], center_y [31:16], center_z [47:32], radius [62:48], zero [63]
  input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,
  // Classification results
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // relation [1:0], zero [7:2]
  output logic [OUT_TDATA_WIDTH-1:0] m_tdata
);

  // Box registers
  logic signed [COORD_WIDTH-1:0] box_min_x, box_min_y, box_min_z;
  logic signed [COORD_WIDTH-1:0] box_max_x, box_max_y, box_max_z;
  logic [2:0]                    cfg_idx;
  logic                          cfg_wr;
  logic signed [COORD_WIDTH-1:0] cfg_rd;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      box_min_x <= '0;
      box_min_y <= '0;
      box_min_z <= '0;
      box_max_x <= '0;
      box_max_y <= '0;
      box_max_z <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MIN_X: box_min_x <= pwdata[COORD_WIDTH-1:0];
        REG_MIN_Y: box_min_y <= pwdata[COORD_WIDTH-1:0];
        REG_MIN_Z: box_min_z <= pwdata[COORD_WIDTH-1:0];
        REG_MAX_X: box_max_x <= pwdata[COORD_WIDTH-1:0];
        REG_MAX_Y: box_max_y <= pwdata[COORD_WIDTH-1:0];
        REG_MAX_Z: box_max_z <= pwdata[COORD_WIDTH-1:0];
        default: ;  // unmapped address: drop the write
      endcase
    end
  end

  // Read back sign-extended; unmapped addresses read zero.
  always_comb begin
    unique case (cfg_idx)
      REG_MIN_X: cfg_rd = box_min_x;
      REG_MIN_Y: cfg_rd = box_min_y;
      REG_MIN_Z: cfg_rd = box_min_z;
      REG_MAX_X: cfg_rd = box_max_x;
      REG_MAX_Y: cfg_rd = box_max_y;
      REG_MAX_Z: cfg_rd = box_max_z;
      default:   cfg_rd = '0;
    endcase
    prdata = {{(CFG_DATA_WIDTH-COORD_WIDTH){cfg_rd[COORD_WIDTH-1]}}, cfg_rd};
  end

  // Unpack the request
  logic signed [COORD_WIDTH-1:0] in_cx, in_cy, in_cz;
  logic        [RADIUS_WIDTH-1:0] in_r;

  assign in_cx = s_tdata[COORD_WIDTH-1:0];
  assign in_cy = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
  assign in_cz = s_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
  assign in_r  = s_tdata[IN_BITS-1:3*COORD_WIDTH];

  // Pipeline control: each stage loads when empty or when its successor loads.
  logic     v1, v2, v3, v4;
  logic     en1, en2, en3, en4;
  logic     skid_ready;
  sbc_adv_t adv;

  assign en4      = !v4 || skid_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;
  assign adv.s1   = en1;
  assign adv.s2   = en2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // Stages one and two per axis
  logic [SQ_WIDTH-1:0] sq_x, sq_y, sq_z;
  logic                in_x, in_y, in_z;

  sbc_axis u_axis_x (
    .clk    (clk),
    .adv    (adv),
    .center (in_cx),
    .lo     (box_min_x),
    .hi     (box_max_x),
    .radius (in_r),
    .sq     (sq_x),
    .fits   (in_x)
  );

  sbc_axis u_axis_y (
    .clk    (clk),
    .adv    (adv),
    .center (in_cy),
    .lo     (box_min_y),
    .hi     (box_max_y),
    .radius (in_r),
    .sq     (sq_y),
    .fits   (in_y)
  );

  sbc_axis u_axis_z (
    .clk    (clk),
    .adv    (adv),
    .center (in_cz),
    .lo     (box_min_z),
    .hi     (box_max_z),
    .radius (in_r),
    .sq     (sq_z),
    .fits   (in_z)
  );

  // Radius travels beside the axis stages; square it in stage two.
  logic [RADIUS_WIDTH-1:0] r1;
  logic [RSQ_WIDTH-1:0]    rsq2, rsq3;
  logic [SUM_WIDTH-1:0]    sum3;
  logic                    all_in3;
  relation_t               rel4, rel_next;

  always_ff @(posedge clk) begin
    if (en1) r1 <= in_r;
    if (en2) rsq2 <= r1 * r1;
  end

  // Stage three: sum the squared distances.
  always_ff @(posedge clk) begin
    if (en3) begin
      sum3    <= SUM_WIDTH'(sq_x) + SUM_WIDTH'(sq_y) + SUM_WIDTH'(sq_z);
      rsq3    <= rsq2;
      all_in3 <= in_x && in_y && in_z;
    end
  end

  // Stage four: a zero or positive remainder overlaps; full extent inside contains.
  always_comb begin
    if (sum3 > SUM_WIDTH'(rsq3)) begin
      rel_next = REL_DISJOINT;
    end else if (all_in3) begin
      rel_next = REL_CONTAINS;
    end else begin
      rel_next = REL_INTERSECTS;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) rel4 <= rel_next;
  end

  // Output buffer
  relation_t out_rel;

  sbc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_ready  (skid_ready),
    .in_data   (rel4),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_rel)
  );

  assign m_tdata = {{(OUT_TDATA_WIDTH-2){1'b0}}, out_rel};

endmodule

>>> rtl/core/sbc_axis.sv
// One axis of the classifier: face distance and extent check, then the squared distance.
`timescale 1ns / 1ps

module sbc_axis
  import sbc_pkg::*;
(
  input  logic                          clk,
  input  sbc_adv_t                      adv,
  input  logic signed [COORD_WIDTH-1:0] center,
  input  logic signed [COORD_WIDTH-1:0] lo,
  input  logic signed [COORD_WIDTH-1:0] hi,
  input  logic        [RADIUS_WIDTH-1:0] radius,
  output logic        [SQ_WIDTH-1:0]    sq,
  output logic                          fits
);

  logic signed [COORD_WIDTH:0]   c_e, lo_e, hi_e, d_lo, d_hi;
  logic signed [COORD_WIDTH+1:0] c_w, lo_w, hi_w, r_w;
  logic                          below, above, inside_next;
  logic [DIST_WIDTH-1:0]         face_dist_next;

  logic [DIST_WIDTH-1:0]         face_dist;
  logic                          inside1;

  always_comb begin
    c_e  = {center[COORD_WIDTH-1], center};
    lo_e = {lo[COORD_WIDTH-1], lo};
    hi_e = {hi[COORD_WIDTH-1], hi};
    d_lo = lo_e - c_e;
    d_hi = c_e - hi_e;
    below = (center < lo);
    above = (center > hi);
    if (below) begin
      face_dist_next = d_lo[DIST_WIDTH-1:0];
    end else if (above) begin
      face_dist_next = d_hi[DIST_WIDTH-1:0];
    end else begin
      face_dist_next = '0;
    end
    c_w  = {{2{center[COORD_WIDTH-1]}}, center};
    lo_w = {{2{lo[COORD_WIDTH-1]}}, lo};
    hi_w = {{2{hi[COORD_WIDTH-1]}}, hi};
    r_w  = signed'({3'b000, radius});
    inside_next = ((c_w - r_w) >= lo_w) && ((c_w + r_w) <= hi_w);
  end

  // Stage one: distance to the nearer face and the extent check.
  always_ff @(posedge clk) begin
    if (adv.s1) begin
      face_dist <= face_dist_next;
      inside1   <= inside_next;
    end
  end

  // Stage two: square the distance.
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      sq   <= face_dist * face_dist;
      fits <= inside1;
    end
  end

endmodule

>>> rtl/core/sbc_skid.sv
// Two-entry output buffer that decouples the pipeline from the result consumer.
`timescale 1ns / 1ps

module sbc_skid
  import sbc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  relation_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output relation_t out_data
);

  logic [1:0] count, count_next;
  relation_t  ent0, ent1;
  logic       push, pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = ent0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Head entry shifts forward on a pop; the new request lands behind what remains.
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        ent0 <= ent1;
      end else if (push) begin
        ent0 <= in_data;
      end
      if (push && count == 2'd2) begin
        ent1 <= in_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        ent0 <= in_data;
      end else begin
        ent1 <= in_data;
      end
    end
  end

endmodule
